// ----- rtl/psba_pkg.sv -----
// Shared types, constants and tables for the planar segment bend angle block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package psba_pkg;

  localparam int QUAT_BITS = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_RINGS_DEF = 16;

  // Quaternion products are rescaled to 30 fraction bits.
  localparam int PROD_BITS = 2 * QUAT_BITS;
  localparam int PROD_SHIFT = 2 * (QUAT_BITS - 1) - 30;

  // Datapath width of the rotation entries and of the CORDIC registers.
  localparam int CW = 34;
  localparam int ITER_W = 5;
  localparam int JOBQ_DEPTH = 2;

  localparam logic signed [CW-1:0] ONE30 = 34'sd1073741824;
  localparam logic signed [CW-1:0] PI30 = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALFPI30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] INVGAIN30 = 34'sd652032874;
  localparam logic [47:0] PI30_HALF = 48'd1686629713;
  localparam logic [47:0] PI30_DEN = 48'd3373259426;
  // floor(2^63 / PI30): scaled reciprocal for the angle increment estimate.
  localparam logic [31:0] INC_RECIP = 32'((64'd1 << 63) / 64'd3373259426);
  localparam logic [61:0] SQRT_TOP_BIT = 62'd1 << 60;
  localparam logic [61:0] ONE60 = 62'd1 << 60;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
    logic signed [QUAT_BITS-1:0] quat_w;
    logic                        frame_end;
  } psba_in_t;

  typedef struct packed {
    logic [15:0] bend_angle;
    logic [3:0]  segment_number;
    logic        frame_done;
  } psba_out_t;

  // One classified ring: the two rotation entries that the back end needs.
  typedef struct packed {
    logic signed [CW-1:0] r01;
    logic signed [CW-1:0] r11;
    logic                 last;
  } psba_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } psba_front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ROT,
    B_MULC,
    B_MULS,
    B_SQR,
    B_SQRT,
    B_PRE,
    B_VEC,
    B_CLAMP,
    B_DIV,
    B_DONE
  } psba_back_state_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [ITER_W-1:0] i);
    logic signed [CW-1:0] v;
    unique case (i)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      5'd24: v = 34'sh00000003F;
      5'd25: v = 34'sh00000001F;
      5'd26: v = 34'sh00000000F;
      5'd27: v = 34'sh000000007;
      5'd28: v = 34'sh000000003;
      5'd29: v = 34'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/psba_front.sv -----
// Front end: takes quaternion transfers and forms the rotation entries R01, R11
// with one shared multiplier. Depends on psba_pkg.
`timescale 1ns / 1ps

module psba_front import psba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  psba_in_t  in_data,
  output logic      job_valid,
  input  logic      job_ready,
  output psba_job_t job
);

  psba_front_state_t state_r, state_nxt;
  psba_in_t q_r, q_nxt;
  logic [1:0] step_r, step_nxt;
  logic signed [CW-1:0] acc01_r, acc01_nxt, acc11_r, acc11_nxt;
  logic signed [QUAT_BITS-1:0] op_a, op_b;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [CW-1:0] prod30;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_MUL;
      F_MUL:  if (step_r == 2'd3) state_nxt = F_PUSH;
      F_PUSH: if (job_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == F_IDLE);
    job_valid = (state_r == F_PUSH);
    job.r01   = acc01_r <<< 1;
    job.r11   = (acc11_r <<< 1) - ONE30;
    job.last  = q_r.frame_end;
  end

  always_comb begin
    unique case (step_r)
      2'd0: begin op_a = q_r.quat_x; op_b = q_r.quat_y; end
      2'd1: begin op_a = q_r.quat_w; op_b = q_r.quat_z; end
      2'd2: begin op_a = q_r.quat_w; op_b = q_r.quat_w; end
      default: begin op_a = q_r.quat_y; op_b = q_r.quat_y; end
    endcase
    prod   = op_a * op_b;
    prod30 = CW'(prod >>> PROD_SHIFT);

    q_nxt     = q_r;
    step_nxt  = step_r;
    acc01_nxt = acc01_r;
    acc11_nxt = acc11_r;
    if (state_r == F_IDLE && in_valid) begin
      q_nxt    = in_data;
      step_nxt = 2'd0;
    end
    if (state_r == F_MUL) begin
      step_nxt = step_r + 2'd1;
      unique case (step_r)
        2'd0: acc01_nxt = prod30;
        2'd1: acc01_nxt = acc01_r - prod30;
        2'd2: acc11_nxt = prod30;
        default: acc11_nxt = acc11_r + prod30;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    q_r     <= q_nxt;
    step_r  <= step_nxt;
    acc01_r <= acc01_nxt;
    acc11_r <= acc11_nxt;
  end

endmodule

// ----- rtl/psba_fifo.sv -----
// Short job queue between the front and back ends, built from registers.
// Depends on psba_pkg for the job type and depth.
`timescale 1ns / 1ps

module psba_fifo import psba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  psba_job_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output psba_job_t rd_data
);

  localparam int PW = $clog2(JOBQ_DEPTH);

  psba_job_t mem_r [JOBQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != (PW + 1)'(JOBQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + PW'(1);
      if (do_rd) rp_r <= rp_r + PW'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + (PW + 1)'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - (PW + 1)'(1);
    end
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- rtl/psba_back.sv -----
// Back end: sin/cos CORDIC of the accumulated angle, de-rotation, square root,
// acos by vectoring CORDIC and the angle increment. Depends on psba_pkg.
`timescale 1ns / 1ps

module psba_back import psba_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int MAX_RINGS    = MAX_RINGS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  psba_job_t job,
  output logic      out_valid,
  input  logic      out_ready,
  output psba_out_t out_data
);

  localparam int RW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);
  localparam logic [ITER_W-1:0] LAST_DIV = ITER_W'(2);

  psba_back_state_t state_r, state_nxt;
  psba_job_t job_r, job_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [RW-1:0] ring_r, ring_nxt;
  logic flip_r, flip_nxt;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [35:0] pc_r, pc_nxt;
  logic signed [31:0] c_r, c_nxt;
  logic [61:0] t_r, t_nxt, sq_r, sq_nxt, bit_r, bit_nxt;
  logic [31:0] ang_r, ang_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [15:0] q_r, q_nxt;
  psba_out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic load;
  logic signed [15:0] s_raw;
  logic signed [16:0] s_fold;
  logic fold;
  logic signed [50:0] zprod;
  logic signed [CW-1:0] dx, dy, co, si, atan_v;
  logic signed [31:0] co32, si32;
  logic signed [65:0] mprod;
  logic signed [36:0] cdiff;
  logic signed [63:0] csq;
  logic [61:0] sq_sum;
  logic signed [CW-1:0] zc;
  logic [63:0] rprod;
  logic [47:0] nrm;

  assign load = (state_r == B_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (job_valid) state_nxt = B_ROT;
      B_ROT:   if (iter_r == LAST_ITER) state_nxt = B_MULC;
      B_MULC:  state_nxt = B_MULS;
      B_MULS:  state_nxt = B_SQR;
      B_SQR:   state_nxt = B_SQRT;
      B_SQRT:  if (bit_r[0]) state_nxt = B_PRE;
      B_PRE:   state_nxt = B_VEC;
      B_VEC:   if (iter_r == LAST_ITER) state_nxt = B_CLAMP;
      B_CLAMP: state_nxt = B_DIV;
      B_DIV:   if (iter_r == LAST_DIV) state_nxt = B_DONE;
      B_DONE:  if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state_r == B_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_comb begin
    // Fold the binary angle into [-pi/2, pi/2]; a fold by pi negates sin and cos.
    s_raw = signed'(sum_r);
    fold  = 1'b0;
    s_fold = 17'(s_raw);
    if (s_raw > 16'sd16384) begin
      s_fold = 17'(s_raw) - 17'sd32768;
      fold   = 1'b1;
    end else if (s_raw < -16'sd16384) begin
      s_fold = 17'(s_raw) + 17'sd32768;
      fold   = 1'b1;
    end
    zprod  = 51'(s_fold) * 51'(PI30);
    dx     = y_r >>> iter_r;
    dy     = x_r >>> iter_r;
    atan_v = atan_q30(iter_r);
    co     = flip_r ? -x_r : x_r;
    si     = flip_r ? -y_r : y_r;
    co32   = 32'(co);
    si32   = 32'(si);
    mprod  = (state_r == B_MULC) ? 66'(co32) * 66'(job_r.r11)
                                 : 66'(si32) * 66'(job_r.r01);
    cdiff  = 37'(pc_r) - 37'(mprod >>> 30);
    csq    = 64'(c_r) * 64'(c_r);
    sq_sum = sq_r + bit_r;
    zc     = z_r;
    if (z_r < 0) zc = '0;
    if (z_r > PI30) zc = PI30;
    rprod  = 64'(ang_r) * 64'(INC_RECIP);
    nrm    = (48'(ang_r) << 15) + PI30_HALF;

    job_nxt = job_r;  iter_nxt = iter_r;  sum_nxt = sum_r;  ring_nxt = ring_r;
    flip_nxt = flip_r;  x_nxt = x_r;  y_nxt = y_r;  z_nxt = z_r;
    pc_nxt = pc_r;  c_nxt = c_r;  t_nxt = t_r;  sq_nxt = sq_r;  bit_nxt = bit_r;
    ang_nxt = ang_r;  rem_nxt = rem_r;  q_nxt = q_r;
    out_nxt = out_r;  out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_nxt  = job;
          flip_nxt = fold;
          x_nxt    = INVGAIN30;
          y_nxt    = '0;
          z_nxt    = CW'(zprod >>> 15);
          iter_nxt = '0;
        end
      end
      B_ROT, B_VEC: begin
        if ((state_r == B_ROT) ? !z_r[CW-1] : !y_r[CW-1]) begin
          x_nxt = (state_r == B_ROT) ? x_r - dx : x_r + dx;
          y_nxt = (state_r == B_ROT) ? y_r + dy : y_r - dy;
          z_nxt = (state_r == B_ROT) ? z_r - atan_v : z_r + atan_v;
        end else begin
          x_nxt = (state_r == B_ROT) ? x_r + dx : x_r - dx;
          y_nxt = (state_r == B_ROT) ? y_r - dy : y_r + dy;
          z_nxt = (state_r == B_ROT) ? z_r + atan_v : z_r - atan_v;
        end
        iter_nxt = (iter_r == LAST_ITER) ? '0 : iter_r + ITER_W'(1);
      end
      B_MULC: pc_nxt = 36'(mprod >>> 30);
      B_MULS: begin
        if (cdiff > 37'(ONE30)) c_nxt = 32'(ONE30);
        else if (cdiff < -37'(ONE30)) c_nxt = -32'(ONE30);
        else c_nxt = 32'(cdiff);
      end
      B_SQR: begin
        t_nxt   = ONE60 - 62'(csq);
        sq_nxt  = '0;
        bit_nxt = SQRT_TOP_BIT;
      end
      B_SQRT: begin
        if (t_r >= sq_sum) begin
          t_nxt  = t_r - sq_sum;
          sq_nxt = (sq_r >> 1) + bit_r;
        end else begin
          sq_nxt = sq_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      B_PRE: begin
        // A negative argument starts a quarter turn ahead.
        if (c_r < 0) begin
          x_nxt = CW'(sq_r);
          y_nxt = -CW'(c_r);
          z_nxt = HALFPI30;
        end else begin
          x_nxt = CW'(c_r);
          y_nxt = CW'(sq_r);
          z_nxt = '0;
        end
        iter_nxt = '0;
      end
      B_CLAMP: begin
        ang_nxt  = 32'(zc);
        q_nxt    = '0;
        iter_nxt = '0;
      end
      B_DIV: begin
        // The reciprocal estimate is at most two low; the exact remainder settles it.
        if (iter_r == '0) begin
          q_nxt = 16'(rprod >> 48);
        end else if (iter_r == ITER_W'(1)) begin
          rem_nxt = nrm - 48'(q_r) * PI30_DEN;
        end else if (rem_r >= (PI30_DEN << 1)) begin
          q_nxt = q_r + 16'd2;
        end else if (rem_r >= PI30_DEN) begin
          q_nxt = q_r + 16'd1;
        end
        iter_nxt = iter_r + ITER_W'(1);
      end
      B_DONE: begin
        if (load) begin
          out_nxt.bend_angle     = 16'((33'(ang_r) + 33'd32768) >> 16);
          out_nxt.segment_number = 4'(ring_r);
          out_nxt.frame_done     = job_r.last;
          out_valid_nxt          = 1'b1;
          if (job_r.last) begin
            sum_nxt  = '0;
            ring_nxt = '0;
          end else begin
            sum_nxt = sum_r + q_r;
            if (ring_r != RW'(MAX_RINGS - 1)) ring_nxt = ring_r + RW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_r       <= '0;
      ring_r      <= '0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      ring_r      <= ring_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
    end
    job_r  <= job_nxt;
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    pc_r   <= pc_nxt;
    c_r    <= c_nxt;
    t_r    <= t_nxt;
    sq_r   <= sq_nxt;
    bit_r  <= bit_nxt;
    ang_r  <= ang_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    out_r  <= out_nxt;
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_r <= RW'(MAX_RINGS - 1))
    else $error("ring counter passed its limit");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (load && job_r.last) |=> (sum_r == '0 && ring_r == '0))
    else $error("frame end did not clear the running angle");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == B_DONE)
    else $error("result appeared outside the completion step");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.bend_angle <= 16'd51472)
    else $error("bend angle above pi");

endmodule

// ----- rtl/planar_segment_bend_angle_top.sv -----
// Planar segment bend angle, top level: front end, job queue and back end.
// Depends on psba_pkg, psba_front, psba_fifo and psba_back.
`timescale 1ns / 1ps

// Each ring quaternion transferred in yields one bend angle (Q2.14, 0 to pi),
// its position in the frame and a frame-done flag, in order. The front end
// takes the transfer, forms the products of R01 and R11 in four steps on one
// shared multiplier and hands the job to the queue, waiting while it is full.
// The back end takes one ring at a time and sets the rate; its work is made
// up of the sin/cos and acos CORDIC iterations, 31 steps of the bit-serial
// square root, three steps of a reciprocal multiply with remainder correction
// for the angle increment, and single load, cosine and sine product, squaring,
// preset, clamp and completion steps. A two-entry queue lets new rings enter
// while the back end works, and the result register lets the next ring start
// while a result waits to be taken.
module planar_segment_bend_angle_top import psba_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int MAX_RINGS    = MAX_RINGS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  psba_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output psba_out_t out_data
);

  psba_job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  psba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  psba_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_job)
  );

  psba_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .MAX_RINGS    (MAX_RINGS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for planar_segment_bend_angle_top: random and directed
// ring quaternions with a scoreboard that predicts each result. Depends on psba_pkg.
`timescale 1ns / 1ps

class bend_scoreboard;
  psba_pkg::psba_out_t pending[$];
  logic [15:0] angle_sum;
  logic [3:0] ring_count;
  int errors;

  function new();
    angle_sum = '0;
    ring_count = '0;
    errors = 0;
  endfunction

  function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function longint prod30(longint a, longint b);
    return a * b;
  endfunction

  function longint root60(longint t);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > t) b = b >>> 2;
    while (b != 0) begin
      if (t >= r + b) begin
        t = t - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function longint arctab(int i);
    return longint'(psba_pkg::atan_q30(i[4:0]));
  endfunction

  function void rotate_sum(input logic [15:0] bam, output longint co, output longint si);
    int s;
    bit flip;
    longint x, y, z, dx, dy;
    s = int'($signed(bam));
    flip = 0;
    x = 652032874;
    y = 0;
    if (s > 16384) begin
      s = s - 32768;
      flip = 1;
    end else if (s < -16384) begin
      s = s + 32768;
      flip = 1;
    end
    z = asr(longint'(s) * 64'sd3373259426, 15);
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctab(i);
      end else begin
        x += dx; y -= dy; z += arctab(i);
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endfunction

  function longint arccos30(longint c);
    longint x, y, z, t, dx, dy;
    x = c;
    z = 0;
    y = root60((64'sd1 << 60) - c * c);
    if (x < 0) begin
      t = x; x = y; y = -t; z = 64'sd1686629713;
    end
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += arctab(i);
      end else begin
        x -= dx; y += dy; z -= arctab(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sd3373259426) z = 64'sd3373259426;
    return z;
  endfunction

  function void note_ring(psba_pkg::psba_in_t q);
    longint qx, qy, qz, qw, r01, r11, co, si, c, ang, inc;
    psba_pkg::psba_out_t res;
    qx = longint'(q.quat_x);
    qy = longint'(q.quat_y);
    qz = longint'(q.quat_z);
    qw = longint'(q.quat_w);
    r01 = 2 * (prod30(qx, qy) - prod30(qw, qz));
    r11 = 2 * (prod30(qw, qw) + prod30(qy, qy)) - (64'sd1 << 30);
    rotate_sum(angle_sum, co, si);
    c = asr(co * r11, 30) - asr(si * r01, 30);
    if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
    if (c < -(64'sd1 << 30)) c = -(64'sd1 << 30);
    ang = arccos30(c);
    res.bend_angle = 16'((ang + 32768) >>> 16);
    res.segment_number = ring_count;
    res.frame_done = q.frame_end;
    pending = {pending, res};
    inc = (ang * 32768 + 64'sd1686629713) / 64'sd3373259426;
    if (q.frame_end) begin
      angle_sum = '0;
      ring_count = '0;
    end else begin
      angle_sum = angle_sum + 16'(inc);
      if (ring_count != 4'd15) ring_count++;
    end
  endfunction

  function void check_result(psba_pkg::psba_out_t got);
    psba_pkg::psba_out_t want;
    if (pending.size() == 0) begin
      $error("unexpected result %h", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.bend_angle !== want.bend_angle) begin
      $error("bend_angle expected %0d actual %0d", want.bend_angle, got.bend_angle);
      errors++;
    end
    if (got.segment_number !== want.segment_number) begin
      $error("segment_number expected %0d actual %0d", want.segment_number,
             got.segment_number);
      errors++;
    end
    if (got.frame_done !== want.frame_done) begin
      $error("frame_done expected %0d actual %0d", want.frame_done, got.frame_done);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import psba_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  psba_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  psba_out_t out_data;

  bend_scoreboard sb = new();
  bit hold_sink = 0;
  int idle_cycles = 0;

  planar_segment_bend_angle_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Quaternion of a z-tilted bend: mostly well-formed unit quaternions, some raw noise.
  function automatic psba_in_t random_ring(bit last);
    psba_in_t q;
    real th, ph;
    if ($urandom_range(0, 9) < 7) begin
      th = $urandom_range(0, 10000) * 3.14159265 / 10000.0;
      ph = $urandom_range(0, 10000) * 6.2831853 / 10000.0;
      q.quat_w = 16'($rtoi(32767.0 * $cos(th / 2)));
      q.quat_x = 16'($rtoi(32767.0 * $sin(th / 2) * $cos(ph)));
      q.quat_y = 16'($rtoi(32767.0 * $sin(th / 2) * $sin(ph)));
      q.quat_z = 16'($urandom_range(0, 2000) - 1000);
    end else begin
      q.quat_x = 16'($urandom);
      q.quat_y = 16'($urandom);
      q.quat_z = 16'($urandom);
      q.quat_w = 16'($urandom);
    end
    q.frame_end = last;
    return q;
  endfunction

  // Valid stays high after the transfer until the caller offers the next ring or idles.
  task automatic send_ring(psba_in_t q);
    in_data <= q;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_ring(q);
    @(negedge clk);
  endtask

  task automatic send_with_gap(psba_in_t q);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    send_ring(q);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Sink: random stalls, or a long hold-off while the source keeps pushing.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ready <= 0;
        repeat (600) @(negedge clk);
        hold_sink = 0;
      end
      g = gap_len();
      if (g != 0) begin
        out_ready <= 0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles > 5000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    psba_in_t q;
    int len;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, identity, inverted ring, overlong frame.
    q = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}; send_ring(q);
    q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0}; send_ring(q);
    q = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0}; send_ring(q);
    q = '{16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0}; send_ring(q);
    q = '{16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0}; send_ring(q);
    q = '{16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 1'b1}; send_ring(q);
    q = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}; send_ring(q);
    q = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh8000, 1'b1}; send_ring(q);
    // Seventeen rings in one frame push the ring counter into saturation.
    for (int i = 0; i < 17; i++) send_ring(random_ring(i == 16));

    // Hold the sink off while the source keeps offering rings.
    hold_sink = 1;
    for (int i = 0; i < 12; i++) send_ring(random_ring(i == 11));
    // Pause until every result has drained.
    wait_drained();

    for (int n = 0; n < 1820; ) begin
      len = $urandom_range(0, 9) == 0 ? $urandom_range(15, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_with_gap(random_ring(i == len - 1 || $urandom_range(0, 40) == 0));
        n++;
      end
      if ($urandom_range(0, 60) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
